>>> hw/rtl/cpd_pkg.sv
// cpd_pkg: shared types and constants for the cookie pair percent decoder
// result item record, per-item result bundle, character codes, hex decode
// no dependencies
package cpd_pkg;

  localparam int MaxResults = 4;
  localparam int CountW     = $clog2(MaxResults + 1);

  // result kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VAL    = 2'd1;
  localparam logic [1:0] KIND_COMMIT = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  // header characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       stop;
  } cpd_res_t;

  typedef struct packed {
    logic [CountW-1:0]           count;
    cpd_res_t [MaxResults-1:0]   res;
  } cpd_bundle_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/cpd_if.sv
// cpd_if: valid/ready channels of the cookie pair percent decoder
// header byte channel and decoded result channel
// no dependencies
interface cpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface cpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       stopped_early;
  logic       out_last;

  modport source (output valid, out_kind, out_byte, stopped_early, out_last, input ready);
  modport sink   (input valid, out_kind, out_byte, stopped_early, out_last, output ready);
endinterface

>>> hw/rtl/cpd_step.sv
// cpd_step: parser state and the per-byte decode step
// produces all results of one header byte in a single pass
// depends on cpd_pkg
module cpd_step import cpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  output cpd_bundle_t bundle
);

  typedef enum logic [2:0] {
    PH_SKIP_KEY  = 3'd0,
    PH_KEY       = 3'd1,
    PH_AFTER_KEY = 3'd2,
    PH_SKIP_VAL  = 3'd3,
    PH_VAL       = 3'd4,
    PH_AFTER_VAL = 3'd5,
    PH_STOPPED   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  // a byte revisits the phase logic at most four times
  localparam int PassMax = 5;

  phase_t      parse_phase, parse_phase_next;
  esc_t        escape_phase, escape_phase_next;
  logic [7:0]  held_digit, held_digit_next;

  cpd_bundle_t bnd;
  logic        again;
  logic [1:0]  kd;
  logic [4:0]  hc;
  logic [4:0]  hh;
  logic        delim;

  function automatic cpd_bundle_t push(input cpd_bundle_t b, input logic [1:0] kind,
                                       input logic [7:0] data, input logic stop);
    cpd_bundle_t r;
    r = b;
    if (r.count < CountW'(MaxResults)) begin
      r.res[r.count[$clog2(MaxResults)-1:0]] = '{kind: kind, data: data, stop: stop};
      r.count = r.count + CountW'(1);
    end
    return r;
  endfunction

  assign hc = hex_digit(in_byte);

  always_comb begin
    parse_phase_next  = parse_phase;
    escape_phase_next = escape_phase;
    held_digit_next   = held_digit;
    bnd   = '0;
    again = 1'b1;
    kd    = KIND_KEY;
    hh    = '0;
    delim = 1'b0;
    for (int i = 0; i < PassMax; i++) begin
      if (again) begin
        again = 1'b0;
        unique case (parse_phase_next)
          PH_SKIP_KEY: begin
            if (end_of_text) begin
              bnd = push(bnd, KIND_FINISH, 8'h00, 1'b0);
              escape_phase_next = ESC_NONE;
            end else if (in_byte != CH_SPACE) begin
              parse_phase_next = PH_KEY;
              again = 1'b1;
            end
          end
          PH_KEY, PH_VAL: begin
            kd = (parse_phase_next == PH_KEY) ? KIND_KEY : KIND_VAL;
            unique case (escape_phase_next)
              ESC_PCT: begin
                if (!end_of_text && hc[4]) begin
                  held_digit_next   = in_byte;
                  escape_phase_next = ESC_DIGIT;
                end else begin
                  bnd = push(bnd, kd, CH_PCT, 1'b0);
                  escape_phase_next = ESC_NONE;
                  again = 1'b1;
                end
              end
              ESC_DIGIT: begin
                hh = hex_digit(held_digit_next);
                if (!end_of_text && hc[4]) begin
                  bnd = push(bnd, kd, {hh[3:0], hc[3:0]}, 1'b0);
                end else begin
                  bnd = push(bnd, kd, CH_PCT, 1'b0);
                  bnd = push(bnd, kd, held_digit_next, 1'b0);
                  again = 1'b1;
                end
                escape_phase_next = ESC_NONE;
              end
              default: begin
                escape_phase_next = ESC_NONE;
                delim = end_of_text || in_byte == CH_SPACE || in_byte == CH_SEMI ||
                        (kd == KIND_KEY && in_byte == CH_EQ);
                if (delim) begin
                  parse_phase_next = (kd == KIND_KEY) ? PH_AFTER_KEY : PH_AFTER_VAL;
                  again = 1'b1;
                end else if (in_byte == CH_PLUS) begin
                  bnd = push(bnd, kd, CH_SPACE, 1'b0);
                end else if (in_byte == CH_PCT) begin
                  escape_phase_next = ESC_PCT;
                end else begin
                  bnd = push(bnd, kd, in_byte, 1'b0);
                end
              end
            endcase
          end
          PH_AFTER_KEY: begin
            if (end_of_text) begin
              bnd = push(bnd, KIND_COMMIT, 8'h00, 1'b0);
              bnd = push(bnd, KIND_FINISH, 8'h00, 1'b0);
              parse_phase_next  = PH_SKIP_KEY;
              escape_phase_next = ESC_NONE;
            end else if (in_byte == CH_EQ) begin
              parse_phase_next = PH_SKIP_VAL;
            end else if (in_byte != CH_SPACE) begin
              parse_phase_next = PH_STOPPED;
            end
          end
          PH_SKIP_VAL: begin
            if (end_of_text) begin
              bnd = push(bnd, KIND_COMMIT, 8'h00, 1'b0);
              bnd = push(bnd, KIND_FINISH, 8'h00, 1'b0);
              parse_phase_next  = PH_SKIP_KEY;
              escape_phase_next = ESC_NONE;
            end else if (in_byte != CH_SPACE) begin
              parse_phase_next = PH_VAL;
              again = 1'b1;
            end
          end
          PH_AFTER_VAL: begin
            if (end_of_text) begin
              bnd = push(bnd, KIND_COMMIT, 8'h00, 1'b0);
              bnd = push(bnd, KIND_FINISH, 8'h00, 1'b0);
              parse_phase_next  = PH_SKIP_KEY;
              escape_phase_next = ESC_NONE;
            end else if (in_byte == CH_SEMI) begin
              bnd = push(bnd, KIND_COMMIT, 8'h00, 1'b0);
              parse_phase_next = PH_SKIP_KEY;
            end else if (in_byte != CH_SPACE) begin
              // junk after a value drops the pair
              parse_phase_next = PH_SKIP_KEY;
            end
          end
          default: begin
            if (end_of_text) begin
              bnd = push(bnd, KIND_FINISH, 8'h00, 1'b1);
              parse_phase_next  = PH_SKIP_KEY;
              escape_phase_next = ESC_NONE;
            end else begin
              parse_phase_next = PH_STOPPED;
            end
          end
        endcase
      end
    end
  end

  assign bundle = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase  <= PH_SKIP_KEY;
      escape_phase <= ESC_NONE;
      held_digit   <= 8'h00;
    end else if (advance) begin
      parse_phase  <= parse_phase_next;
      escape_phase <= escape_phase_next;
      held_digit   <= held_digit_next;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    advance && end_of_text |=> parse_phase == PH_SKIP_KEY && escape_phase == ESC_NONE)
    else $error("terminator did not return parser to key start");

  a_escape_in_token: assert property (@(posedge clk) disable iff (rst)
    escape_phase != ESC_NONE |-> parse_phase == PH_KEY || parse_phase == PH_VAL)
    else $error("escape pending outside key or value");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    advance |-> bundle.count <= CountW'(MaxResults))
    else $error("too many results for one byte");

endmodule

>>> hw/rtl/cookie_pair_percent_decoder_core.sv
// cookie_pair_percent_decoder_core: top level of the cookie pair decoder
// input register, decode step, and a four-slot result bank toward the sink
// depends on cpd_pkg, cpd_if, cpd_step
//
//   port  dir     payload                                     meaning
//   hdr   sink    in_byte[7:0], end_of_text                    header bytes, terminator
//   res   source  out_kind[1:0], out_byte[7:0],                key/value bytes, commit,
//                 stopped_early, out_last                      finish
//
// a header byte is registered, decoded in one pass and its 0 to 4 results are
// loaded into the result bank; results leave one per cycle while the sink is ready
// one byte per cycle while each byte gives at most one result and the sink is ready;
// a byte with more results holds the next byte until the bank drains (single result port)
// hdr.ready stays high while the bank drains its last result into a ready sink
// synchronous active-high reset returns the parser to the start of a key
module cookie_pair_percent_decoder_core import cpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cpd_in_if.sink      hdr,
  cpd_out_if.source   res
);

  localparam int IdxW = $clog2(MaxResults);

  logic              hdr_vld;
  logic [7:0]        hdr_byte;
  logic              hdr_eot;

  cpd_bundle_t       bundle;
  cpd_res_t          slot [MaxResults];
  logic [CountW-1:0] left;
  logic [IdxW-1:0]   rd;

  logic              out_xfer;
  logic              bank_open;
  logic              fire;
  logic [CountW-1:0] last_pos;

  assign out_xfer  = res.valid && res.ready;
  assign bank_open = (left == '0) || (left == CountW'(1) && res.ready);
  assign fire      = hdr_vld && bank_open;
  assign hdr.ready = !hdr_vld || fire;

  cpd_step u_step (
    .clk         (clk),
    .rst         (rst),
    .advance     (fire),
    .in_byte     (hdr_byte),
    .end_of_text (hdr_eot),
    .bundle      (bundle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_vld <= 1'b0;
    end else if (hdr.ready) begin
      hdr_vld <= hdr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.valid && hdr.ready) begin
      hdr_byte <= hdr.in_byte;
      hdr_eot  <= hdr.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      rd   <= '0;
    end else if (fire) begin
      left <= bundle.count;
      rd   <= '0;
    end else if (out_xfer) begin
      left <= left - CountW'(1);
      rd   <= rd + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < MaxResults; i++) begin
        slot[i] <= bundle.res[i];
      end
    end
  end

  assign res.valid         = (left != '0);
  assign res.out_kind      = slot[rd].kind;
  assign res.out_byte      = slot[rd].data;
  assign res.stopped_early = slot[rd].stop;
  assign res.out_last      = (left == CountW'(1));

  assign last_pos = bundle.count - CountW'(1);

  a_eot_finishes: assert property (@(posedge clk) disable iff (rst)
    fire && hdr_eot |-> bundle.count != '0 &&
                        bundle.res[last_pos[IdxW-1:0]].kind == KIND_FINISH)
    else $error("terminator without finish result");

  a_silent_byte: assert property (@(posedge clk) disable iff (rst)
    fire && bundle.count == '0 |=> !res.valid)
    else $error("result shown for a byte that gave none");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    out_xfer && left == CountW'(1) && !fire |=> !res.valid)
    else $error("bank not empty after last transfer");

endmodule

>>> test/tb_cookie_pair_percent_decoder_core.sv
`timescale 1ns / 1ps
// testbench for cookie_pair_percent_decoder_core: directed and random headers,
// results checked against a local pair splitter and percent decoder
// depends on cpd_pkg, cpd_if and the core
module tb_cookie_pair_percent_decoder_core;
  import cpd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 280;
  localparam int ShownErrors = 10;

  typedef enum logic [2:0] {
    P_LEAD, P_KEY, P_KEY_TAIL, P_VAL_LEAD, P_VAL, P_VAL_TAIL, P_HALT
  } phase_e;

  typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DIGIT} esc_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       stop;
    logic       last;
  } decoded_t;

  logic clk = 1'b0;
  logic rst;

  cpd_in_if  hdr ();
  cpd_out_if res ();

  cookie_pair_percent_decoder_core dut (
    .clk (clk),
    .rst (rst),
    .hdr (hdr),
    .res (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder state as the block should hold it
  phase_e     phase;
  esc_e       esc;
  logic [7:0] held_digit;

  decoded_t   pending_results[$];
  decoded_t   byte_results[MaxResults];
  int         byte_result_n;

  int         fail_count = 0;
  int         cycle_count = 0;
  int         live_items = 0;
  bit         no_idle = 1'b0;
  decoded_t   head;

  function automatic bit hex_nib(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
      return 1'b1;
    end
    // 'A'..'F' and 'a'..'f' share the low nibble 1..6
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic note(input logic [1:0] kind, input logic [7:0] data, input logic stop);
    if (byte_result_n < MaxResults) begin
      byte_results[byte_result_n] = '{kind: kind, data: data, stop: stop, last: 1'b0};
      byte_result_n++;
    end
  endtask

  task automatic end_header(input logic stop);
    note(KIND_FINISH, 8'h00, stop);
    phase = P_LEAD;
    esc   = ESC_NONE;
  endtask

  task automatic decode_header_byte(input logic [7:0] c, input logic eot);
    bit         redo;
    logic [1:0] kind;
    logic [3:0] hi;
    logic [3:0] lo;
    byte_result_n = 0;
    redo = 1'b1;
    while (redo) begin
      redo = 1'b0;
      case (phase)
        P_LEAD: begin
          if (eot) end_header(1'b0);
          else if (c != CH_SPACE) begin
            phase = P_KEY;
            redo  = 1'b1;
          end
        end
        P_KEY, P_VAL: begin
          kind = (phase == P_KEY) ? KIND_KEY : KIND_VAL;
          if (esc == ESC_PCT) begin
            if (!eot && hex_nib(c, lo)) begin
              held_digit = c;
              esc = ESC_DIGIT;
            end else begin
              // lone '%' goes out raw, the byte is looked at again
              note(kind, CH_PCT, 1'b0);
              esc  = ESC_NONE;
              redo = 1'b1;
            end
          end else if (esc == ESC_DIGIT) begin
            if (!eot && hex_nib(c, lo)) begin
              void'(hex_nib(held_digit, hi));
              note(kind, {hi, lo}, 1'b0);
            end else begin
              note(kind, CH_PCT, 1'b0);
              note(kind, held_digit, 1'b0);
              redo = 1'b1;
            end
            esc = ESC_NONE;
          end else if (eot || c == CH_SPACE || c == CH_SEMI ||
                       (phase == P_KEY && c == CH_EQ)) begin
            phase = (phase == P_KEY) ? P_KEY_TAIL : P_VAL_TAIL;
            redo  = 1'b1;
          end else if (c == CH_PLUS) note(kind, CH_SPACE, 1'b0);
          else if (c == CH_PCT) esc = ESC_PCT;
          else note(kind, c, 1'b0);
        end
        P_KEY_TAIL: begin
          if (eot) begin
            note(KIND_COMMIT, 8'h00, 1'b0);
            end_header(1'b0);
          end else if (c == CH_EQ) phase = P_VAL_LEAD;
          else if (c != CH_SPACE) phase = P_HALT;
        end
        P_VAL_LEAD: begin
          if (eot) begin
            note(KIND_COMMIT, 8'h00, 1'b0);
            end_header(1'b0);
          end else if (c != CH_SPACE) begin
            phase = P_VAL;
            redo  = 1'b1;
          end
        end
        P_VAL_TAIL: begin
          if (eot) begin
            note(KIND_COMMIT, 8'h00, 1'b0);
            end_header(1'b0);
          end else if (c == CH_SEMI) begin
            note(KIND_COMMIT, 8'h00, 1'b0);
            phase = P_LEAD;
          end else if (c != CH_SPACE) phase = P_LEAD;  // junk drops the pair
        end
        default: begin
          if (eot) end_header(1'b1);
        end
      endcase
    end
    if (byte_result_n > 0) byte_results[byte_result_n - 1].last = 1'b1;
    for (int i = 0; i < byte_result_n; i++) pending_results.push_back(byte_results[i]);
  endtask

  // one header transfer, then a random idle stretch with valid low, which may be empty
  task automatic send_item(input logic [7:0] b, input logic eot);
    int gap;
    hdr.in_byte     = b;
    hdr.end_of_text = eot;
    hdr.valid       = 1'b1;
    @(posedge clk);
    while (!hdr.ready) @(posedge clk);
    live_items++;
    decode_header_byte(b, eot);
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      hdr.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_terminator;
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_spaces;
    repeat ($urandom_range(0, 2)) send_item(CH_SPACE, 1'b0);
  endtask

  function automatic logic [7:0] plain_char;
    string pool;
    pool = "abcdefxyzABCDEFXYZ0123456789-._";
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [7:0] hex_char;
    string pool;
    pool = "0123456789abcdefABCDEF";
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  task automatic send_token;
    int pick;
    repeat ($urandom_range(0, 4)) begin
      pick = $urandom_range(0, 11);
      if (pick <= 4) send_item(plain_char(), 1'b0);
      else if (pick == 5) send_item(CH_PLUS, 1'b0);
      else if (pick == 6) begin
        send_item(CH_PCT, 1'b0);
        send_item(hex_char(), 1'b0);
        send_item(hex_char(), 1'b0);
      end else if (pick == 7) begin
        // broken escape: maybe one digit, then any byte at all
        send_item(CH_PCT, 1'b0);
        if ($urandom_range(0, 1)) send_item(hex_char(), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick == 8) send_item(CH_PCT, 1'b0);
      else if (pick == 9) send_item(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
      else send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic send_header;
    int pairs;
    pairs = $urandom_range(1, 3);
    for (int i = 0; i < pairs; i++) begin
      send_spaces();
      send_token();
      send_spaces();
      if ($urandom_range(0, 7) != 0) send_item(CH_EQ, 1'b0);
      else if ($urandom_range(0, 1)) send_item(plain_char(), 1'b0);
      send_spaces();
      send_token();
      send_spaces();
      if (i < pairs - 1 || $urandom_range(0, 1)) begin
        if ($urandom_range(0, 7) != 0) send_item(CH_SEMI, 1'b0);
        else send_item(plain_char(), 1'b0);
      end
    end
    send_terminator();
  endtask

  task automatic send_noise_header;
    repeat ($urandom_range(1, 10)) send_item(8'($urandom_range(0, 255)), 1'b0);
    send_terminator();
  endtask

  // escapes good and bad, '+', zero and all-ones bytes, key closed by end of text
  task automatic test_escapes_and_extremes;
    send_text("a%4A=%2;+");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_terminator();
  endtask

  task automatic test_key_without_equals;
    send_text("b c");
    send_terminator();
  endtask

  // empty key, junk after a value, lone '%', escape cut by end of text
  task automatic test_empty_key_and_junk;
    send_text("=v x%z=%4");
    send_terminator();
  endtask

  task automatic test_random_traffic;
    int start;
    start = live_items;
    while (live_items - start < RandomItems) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) send_noise_header();
      else send_header();
    end
    no_idle = 1'b0;
  endtask

  // result sink with random stalls per transfer
  initial begin
    int stall;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        res.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready = 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= ShownErrors)
          $display("unexpected result: kind %0d byte %02h stop %0d last %0d",
                   res.out_kind, res.out_byte, res.stopped_early, res.out_last);
      end else begin
        head = pending_results.pop_front();
        if (res.out_kind !== head.kind || res.out_byte !== head.data ||
            res.stopped_early !== head.stop || res.out_last !== head.last) begin
          fail_count++;
          if (fail_count <= ShownErrors)
            $display({"result mismatch: expected kind %0d byte %02h stop %0d last %0d,",
                      " got kind %0d byte %02h stop %0d last %0d"},
                     head.kind, head.data, head.stop, head.last,
                     res.out_kind, res.out_byte, res.stopped_early, res.out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    hdr.valid       = 1'b0;
    hdr.in_byte     = 8'h00;
    hdr.end_of_text = 1'b0;
    phase           = P_LEAD;
    esc             = ESC_NONE;
    held_digit      = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_escapes_and_extremes();
    test_key_without_equals();
    test_empty_key_and_junk();
    test_random_traffic();
    hdr.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
